FILE: sv/icl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icl_pkg
// Shared types and constants of the 32-line interrupt controller: command and
// register offset codes, the decoded operation and the request record that
// travels down the row of line cells.
// ----------------------------------------------------------------------------
package icl_pkg;

	// number of interrupt lines
	localparam int unsigned NUM_LINES_DEF = 32;

	// field widths
	localparam int unsigned LINE_W   = 5;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned OFS_W    = 12;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned MASK_W   = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	// register offsets
	localparam logic [OFS_W-1:0] OFS_STATUS      = 12'h000;
	localparam logic [OFS_W-1:0] OFS_NUMBER      = 12'h004;
	localparam logic [OFS_W-1:0] OFS_DISABLE_ALL = 12'h008;
	localparam logic [OFS_W-1:0] OFS_DISABLE     = 12'h00c;
	localparam logic [OFS_W-1:0] OFS_ENABLE      = 12'h010;

	// decoded operation of one request
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LEVEL,
		OP_RD_STATUS,
		OP_RD_NUMBER,
		OP_CLR_ALL,
		OP_DISABLE,
		OP_ENABLE,
		OP_BAD
	} op_t;

	// request record handed from cell to cell
	typedef struct packed {
		op_t               op;
		logic [LINE_W-1:0] line;
		logic              level;
		logic [COUNT_W-1:0] count;
		logic              found;
		logic [LINE_W-1:0] num;
		logic              irq;
		logic              fiq;
	} item_t;

endpackage

FILE: sv/interrupt_controller_32_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_controller_32_line
// Interrupt controller with line level latching, irq and fiq masks, pending
// count and lowest pending line readout.
// ----------------------------------------------------------------------------
// Each request (line level change, register read or register write) flows
// down a row of NUM_LINES line cells, each registering it in turn, and then
// into an output register. The first cell captures the request at the edge
// that takes it. A new request is taken every cycle; the row stalls only when
// a finished result sits in the output register unclaimed while another
// result is arriving behind it. Every result carries the irq and fiq levels
// as they stand after that request. The fiq mask is written through cfg_we
// and cfg_wdata; the user must write it only while no request is in flight,
// which the block itself does not enforce.
module interrupt_controller_32_line
	import icl_pkg::*;
#(
	parameter int unsigned NUM_LINES = NUM_LINES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [MASK_W-1:0]   cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [LINE_W-1:0]   line_index,
	input  logic                line_level,
	input  logic [OFS_W-1:0]    reg_offset,
	input  logic [LINE_W-1:0]   write_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COUNT_W-1:0]  read_data,
	output logic                irq_out,
	output logic                fiq_out,
	output logic                status
);

	logic                   adv;
	logic [NUM_LINES:0]     chain_valid;
	item_t                  chain_item [NUM_LINES+1];
	item_t                  head;

	logic                   out_valid_q;
	logic [COUNT_W-1:0]     read_data_q;
	logic                   irq_q;
	logic                   fiq_q;
	logic                   status_q;
	item_t                  tail;
	logic [COUNT_W-1:0]     tail_data;

	// decode the incoming request
	always_comb begin
		head       = '0;
		head.op    = OP_NOP;
		head.line  = line_index;
		head.level = line_level;
		unique case (command)
			CMD_LEVEL: head.op = OP_LEVEL;
			CMD_READ: begin
				if (reg_offset == OFS_STATUS)      head.op = OP_RD_STATUS;
				else if (reg_offset == OFS_NUMBER) head.op = OP_RD_NUMBER;
				else                               head.op = OP_BAD;
			end
			CMD_WRITE: begin
				head.line = write_value;
				if (reg_offset == OFS_DISABLE_ALL)  head.op = OP_CLR_ALL;
				else if (reg_offset == OFS_DISABLE) head.op = OP_DISABLE;
				else if (reg_offset == OFS_ENABLE)  head.op = OP_ENABLE;
				else                                head.op = OP_BAD;
			end
			default: head.op = OP_NOP;
		endcase
	end

	// row advances unless a result would overrun the held output
	assign adv      = !(out_valid_q && !out_ready && chain_valid[NUM_LINES]);
	assign in_ready = adv;

	assign chain_valid[0] = in_valid;
	assign chain_item[0]  = head;

	// row of line cells
	for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
		icl_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cfg_we   (cfg_we),
			.cfg_bit  (cfg_wdata[i]),
			.valid_in (chain_valid[i]),
			.item_in  (chain_item[i]),
			.valid_out(chain_valid[i+1]),
			.item_out (chain_item[i+1])
		);
	end

	// form the read data from the finished request
	always_comb begin
		tail = chain_item[NUM_LINES];
		unique case (tail.op)
			OP_RD_STATUS: tail_data = tail.count;
			OP_RD_NUMBER: tail_data = tail.found ? COUNT_W'(tail.num) : '0;
			default:      tail_data = '0;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && chain_valid[NUM_LINES]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv && chain_valid[NUM_LINES]) begin
			read_data_q <= tail_data;
			irq_q       <= tail.irq;
			fiq_q       <= tail.fiq;
			status_q    <= (tail.op == OP_BAD);
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_out   = irq_q;
	assign fiq_out   = fiq_q;
	assign status    = status_q;

endmodule

FILE: sv/icl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icl_cell
// One interrupt line: holds its latched level, irq enable and fiq enable,
// applies a passing request to the level and irq enable and adds its contribution to the
// running count, lowest pending line and output flags.
// ----------------------------------------------------------------------------
module icl_cell
	import icl_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  cfg_we,
	input  logic  cfg_bit,
	input  logic  valid_in,
	input  item_t item_in,
	output logic  valid_out,
	output item_t item_out
);

	logic  level_q;
	logic  enable_q;
	logic  fiq_q;
	logic  valid_s1;
	item_t item_s1;

	logic  hit;
	logic  level_n;
	logic  enable_n;
	logic  pend;
	item_t item_n;

	// apply the request to this line
	always_comb begin
		hit      = (item_in.line == LINE_W'(IDX));
		level_n  = level_q;
		enable_n = enable_q;
		if (valid_in) begin
			unique case (item_in.op)
				OP_LEVEL:   if (hit) level_n = item_in.level;
				OP_CLR_ALL: level_n = 1'b0;
				OP_DISABLE: if (hit) enable_n = 1'b0;
				OP_ENABLE:  if (hit) enable_n = 1'b1;
				default:    ;
			endcase
		end
	end

	// accumulate count, lowest pending line and output flags
	always_comb begin
		pend         = level_n & enable_n;
		item_n       = item_in;
		item_n.count = item_in.count + COUNT_W'(pend);
		item_n.irq   = item_in.irq | pend;
		item_n.fiq   = item_in.fiq | (level_n & fiq_q);
		if (!item_in.found && pend) begin
			item_n.found = 1'b1;
			item_n.num   = LINE_W'(IDX);
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 1'b0;
			enable_q <= 1'b0;
			fiq_q    <= 1'b0;
		end else begin
			if (adv && valid_in) begin
				level_q  <= level_n;
				enable_q <= enable_n;
			end
			if (cfg_we) begin
				fiq_q <= cfg_bit;
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_n;
		end
	end

	assign valid_out = valid_s1;
	assign item_out  = item_s1;

endmodule

FILE: tb/icl_response_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icl_response_check
// Watches the request and response channels of the interrupt controller,
// keeps its own copy of the line levels, enable masks and pending count,
// works out the response to each accepted request and compares every
// accepted response with the oldest outstanding one.
// ----------------------------------------------------------------------------
module icl_response_check
	import icl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [MASK_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [LINE_W-1:0]  line_index,
	input  logic               line_level,
	input  logic [OFS_W-1:0]   reg_offset,
	input  logic [LINE_W-1:0]  write_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [COUNT_W-1:0] read_data,
	input  logic               irq_out,
	input  logic               fiq_out,
	input  logic               status,
	output int                 outstanding,
	output int                 errors
);

	typedef struct packed {
		logic [COUNT_W-1:0] data;
		logic               irq;
		logic               fiq;
		logic               bad;
	} answer_t;

	// mirrored controller state
	logic [MASK_W-1:0]  line_lvl;
	logic [MASK_W-1:0]  irq_mask;
	logic [MASK_W-1:0]  fiq_mask;
	logic [COUNT_W-1:0] pend_count;

	// responses owed by the block, oldest first
	answer_t answers_due[$];
	int      mismatches = 0;

	assign errors = mismatches;

	// update the mirrored state for one request and queue its response
	task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] line,
			input logic lvl, input logic [OFS_W-1:0] ofs, input logic [LINE_W-1:0] wval);
		logic [MASK_W-1:0] bitm;
		logic [MASK_W-1:0] hit;
		answer_t ans;
		ans = '0;
		case (cmd)
			CMD_LEVEL: begin
				bitm = MASK_W'(1) << line;
				if (lvl && (line_lvl & bitm) == '0) begin
					if ((irq_mask & bitm) != '0)
						pend_count = pend_count + 1'b1;
					line_lvl = line_lvl | bitm;
				end else if (!lvl && (line_lvl & bitm) != '0) begin
					if ((irq_mask & bitm) != '0)
						pend_count = pend_count - 1'b1;
					line_lvl = line_lvl & ~bitm;
				end
			end
			CMD_READ: begin
				if (ofs == OFS_STATUS) begin
					ans.data = pend_count;
				end else if (ofs == OFS_NUMBER) begin
					// lowest pending enabled line, zero when none
					hit = line_lvl & irq_mask;
					for (int i = MASK_W - 1; i >= 0; i--)
						if (hit[i])
							ans.data = COUNT_W'(i);
				end else begin
					ans.bad = 1'b1;
				end
			end
			CMD_WRITE: begin
				bitm = MASK_W'(1) << wval;
				if (ofs == OFS_DISABLE_ALL) begin
					line_lvl = '0;
					pend_count = '0;
				end else if (ofs == OFS_DISABLE) begin
					if ((irq_mask & bitm) != '0) begin
						if ((line_lvl & bitm) != '0)
							pend_count = pend_count - 1'b1;
						irq_mask = irq_mask & ~bitm;
					end
				end else if (ofs == OFS_ENABLE) begin
					if ((irq_mask & bitm) == '0) begin
						irq_mask = irq_mask | bitm;
						if ((line_lvl & bitm) != '0)
							pend_count = pend_count + 1'b1;
					end
				end else begin
					ans.bad = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ans.irq = |(line_lvl & irq_mask);
		ans.fiq = |(line_lvl & fiq_mask);
		answers_due.push_back(ans);
	endtask

	// compare one accepted response with the oldest owed one
	task automatic check_answer;
		answer_t due;
		if (answers_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: response with none owed: data %0d irq %0b fiq %0b status %0b",
					$time, read_data, irq_out, fiq_out, status);
		end else begin
			due = answers_due.pop_front();
			if (read_data !== due.data || irq_out !== due.irq || fiq_out !== due.fiq ||
					status !== due.bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected data %0d irq %0b fiq %0b status %0b, %s %0d %s %0b %s %0b %s %0b",
						$time, due.data, due.irq, due.fiq, due.bad,
						"got data", read_data, "irq", irq_out, "fiq", fiq_out,
						"status", status);
			end
		end
	endtask

	// config, then requests, then responses, all in one ordered place
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_lvl = '0;
			irq_mask = '0;
			fiq_mask = '0;
			pend_count = '0;
			answers_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				fiq_mask = cfg_wdata;
			if (in_valid && in_ready)
				apply_request(command, line_index, line_level, reg_offset, write_value);
			if (out_valid && out_ready)
				check_answer();
			outstanding <= answers_due.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the interrupt controller with a directed run over every command,
// register offset and corner of the pending count, then with random phases
// under several fiq masks, with random gaps on the request side and random
// stalls on the response side. The response checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import icl_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 105;
	localparam int SETTLE_CYCLES = NUM_LINES_DEF + 8;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [MASK_W-1:0]  cfg_wdata   = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [CMD_W-1:0]   command     = '0;
	logic [LINE_W-1:0]  line_index  = '0;
	logic               line_level  = 1'b0;
	logic [OFS_W-1:0]   reg_offset  = '0;
	logic [LINE_W-1:0]  write_value = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [COUNT_W-1:0] read_data;
	logic               irq_out;
	logic               fiq_out;
	logic               status;
	int                 outstanding;
	int                 errors;

	// stretches without gaps on either side
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	interrupt_controller_32_line dut (.*);

	icl_response_check scoreboard (.*);

	always #1 clk = ~clk;

	// run limit
	initial begin
		#1_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// response side: random stall before each response
	initial begin : rx_side
		int stall;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one request, after a random gap, held until taken
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LINE_W-1:0] line,
			input logic lvl, input logic [OFS_W-1:0] ofs, input logic [LINE_W-1:0] wval);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		line_index  <= line;
		line_level  <= lvl;
		reg_offset  <= ofs;
		write_value <= wval;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending until every owed response is back
	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_fiq_mask(input logic [MASK_W-1:0] mask);
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly good register traffic, some bad offsets and unused commands
	task automatic send_random_request;
		int pick;
		int sel;
		logic [OFS_W-1:0]  ofs;
		logic [LINE_W-1:0] line;
		logic              lvl;
		logic [LINE_W-1:0] wval;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, 19);
		line = LINE_W'($urandom_range(0, 31));
		lvl  = 1'($urandom_range(0, 1));
		wval = LINE_W'($urandom_range(0, 31));
		ofs  = OFS_W'($urandom_range(0, 4095));
		if (pick < 40) begin
			send_request(CMD_LEVEL, line, lvl, ofs, wval);
		end else if (pick < 65) begin
			if (sel < 8)
				ofs = OFS_STATUS;
			else if (sel < 16)
				ofs = OFS_NUMBER;
			send_request(CMD_READ, line, lvl, ofs, wval);
		end else if (pick < 96) begin
			if (sel == 0)
				ofs = OFS_DISABLE_ALL;
			else if (sel < 7)
				ofs = OFS_DISABLE;
			else if (sel < 17)
				ofs = OFS_ENABLE;
			send_request(CMD_WRITE, line, lvl, ofs, wval);
		end else begin
			send_request(CMD_UNUSED, line, lvl, ofs, wval);
		end
	endtask

	initial begin : tx_side
		logic [MASK_W-1:0] phase_mask [PHASES];
		phase_mask[0] = '0;
		phase_mask[1] = '1;
		phase_mask[2] = $urandom();
		phase_mask[3] = 32'h8000_0001;
		phase_mask[4] = $urandom();
		phase_mask[5] = 32'h0000_ffff;

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_fiq_mask('1);

		// directed: empty reads, levels before enables, redundant changes
		send_request(CMD_READ, '0, 1'b0, OFS_STATUS, '0);
		send_request(CMD_READ, '0, 1'b0, OFS_NUMBER, '0);
		send_request(CMD_LEVEL, 5'd0, 1'b1, '0, '0);
		send_request(CMD_LEVEL, 5'd31, 1'b1, '0, '0);
		send_request(CMD_LEVEL, 5'd31, 1'b1, '0, '0);
		send_request(CMD_WRITE, '0, 1'b0, OFS_ENABLE, 5'd0);
		send_request(CMD_WRITE, '0, 1'b0, OFS_ENABLE, 5'd0);
		send_request(CMD_WRITE, '0, 1'b0, OFS_ENABLE, 5'd31);
		send_request(CMD_READ, '0, 1'b0, OFS_STATUS, '0);
		send_request(CMD_READ, '0, 1'b0, OFS_NUMBER, '0);
		send_request(CMD_WRITE, '0, 1'b0, OFS_DISABLE, 5'd0);
		send_request(CMD_WRITE, '0, 1'b0, OFS_DISABLE, 5'd0);
		send_request(CMD_READ, '0, 1'b0, OFS_NUMBER, '0);
		send_request(CMD_LEVEL, 5'd31, 1'b0, '0, '0);
		send_request(CMD_LEVEL, 5'd31, 1'b0, '0, '0);
		send_request(CMD_READ, '0, 1'b0, OFS_STATUS, '0);
		// bad offsets on both read and write, then the unused command
		send_request(CMD_READ, '0, 1'b0, OFS_DISABLE_ALL, '0);
		send_request(CMD_READ, '1, 1'b1, '1, '1);
		send_request(CMD_WRITE, '0, 1'b0, OFS_STATUS, 5'd3);
		send_request(CMD_WRITE, '1, 1'b1, 12'hffc, '1);
		send_request(CMD_UNUSED, '1, 1'b1, '1, '1);
		// clear all levels, enables stay
		send_request(CMD_LEVEL, 5'd17, 1'b1, '0, '0);
		send_request(CMD_WRITE, '0, 1'b0, OFS_DISABLE_ALL, '0);
		send_request(CMD_READ, '0, 1'b0, OFS_STATUS, '0);
		send_request(CMD_READ, '0, 1'b0, OFS_NUMBER, '0);

		// random phases, fiq mask changed only while idle
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_fiq_mask(phase_mask[p]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_random_request();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: files.f
sv/icl_pkg.sv
sv/icl_cell.sv
sv/interrupt_controller_32_line.sv
tb/icl_response_check.sv
tb/testbench.sv
